/* hw/rtl/wse_pkg.sv */
`default_nettype none

package wse_pkg;

   localparam logic [11:0] MAX_FRAME_LEN = 12'd4095;
   localparam logic [11:0] HDR_LEN       = 12'd24;
   localparam logic [11:0] FIXED_LEN     = 12'd12;
   localparam logic [7:0]  MAX_CHARS_RST = 8'd63;
   localparam logic [7:0]  DOT_CHAR      = 8'h2E;

   typedef struct packed {
      logic [7:0] ssid_char;
      logic       ssid_last;
      logic       ssid_empty;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } parse_result_type;

endpackage

`default_nettype wire

/* hw/rtl/wse_parser.sv */
`default_nettype none

module wse_parser (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      item_accept,
   input  wire logic [7:0]                data_byte,
   input  wire logic [11:0]               frame_len,
   input  wire logic                      frame_start,
   input  wire logic [7:0]                max_chars,
   output wse_pkg::parse_result_type      result
);

   localparam logic [2:0] PH_DONE   = 3'd0;
   localparam logic [2:0] PH_HEADER = 3'd1;
   localparam logic [2:0] PH_TAG    = 3'd2;
   localparam logic [2:0] PH_LEN    = 3'd3;
   localparam logic [2:0] PH_SKIP   = 3'd4;
   localparam logic [2:0] PH_SSID   = 3'd5;

   logic [11:0] pos_ff, pos_in;
   logic [2:0]  phase_ff, phase_in;
   logic        long_ff, long_in;
   logic [7:0]  tag_ff, tag_in;
   logic [7:0]  remain_ff, remain_in;

   logic [11:0] tag_base;
   logic [2:0]  eff_phase;
   logic        active;
   logic [3:0]  subtype;
   logic [7:0]  remain_dec;
   logic [7:0]  printable;

   assign tag_base   = long_ff ? (wse_pkg::HDR_LEN + wse_pkg::FIXED_LEN) : wse_pkg::HDR_LEN;
   assign subtype    = data_byte[7:4];
   assign remain_dec = remain_ff - 8'd1;
   assign printable  = (data_byte >= 8'h20 && data_byte < 8'h7F) ? data_byte
                                                                  : wse_pkg::DOT_CHAR;

   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      long_in   = long_ff;
      tag_in    = tag_ff;
      remain_in = remain_ff;
      result    = '0;
      active    = 1'b0;
      eff_phase = phase_ff;

      if (frame_start) begin
         phase_in  = PH_DONE;
         if (frame_len >= wse_pkg::HDR_LEN && data_byte[3:2] == 2'd0) begin
            if ((subtype == 4'd8 || subtype == 4'd5) &&
                frame_len >= wse_pkg::HDR_LEN + wse_pkg::FIXED_LEN + 12'd2) begin
               long_in  = 1'b1;
               phase_in = PH_HEADER;
            end else if (subtype == 4'd4 && frame_len >= wse_pkg::HDR_LEN + 12'd2) begin
               long_in  = 1'b0;
               phase_in = PH_HEADER;
            end
         end
         tag_in    = 8'd0;
         remain_in = 8'd0;
         pos_in    = 12'd1;
      end else begin
         if (pos_ff != wse_pkg::MAX_FRAME_LEN) begin
            pos_in = pos_ff + 12'd1;
         end
         active = (pos_ff < frame_len) && (phase_ff != PH_DONE);
         if (phase_ff == PH_HEADER) begin
            if (pos_ff < tag_base) begin
               active = 1'b0;
            end else begin
               eff_phase = PH_TAG;
               phase_in  = PH_TAG;
            end
         end
         if (active) begin
            case (eff_phase)
               PH_TAG: begin
                  if ({1'b0, pos_ff} + 13'd2 > {1'b0, frame_len}) begin
                     phase_in = PH_DONE;
                  end else begin
                     tag_in   = data_byte;
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  if ({1'b0, pos_ff} + 13'd1 + {5'd0, data_byte} > {1'b0, frame_len}) begin
                     phase_in = PH_DONE;
                  end else if (tag_ff == 8'd0) begin
                     if (data_byte == 8'd0) begin
                        result.valid           = 1'b1;
                        result.item.ssid_char  = 8'd0;
                        result.item.ssid_last  = 1'b1;
                        result.item.ssid_empty = 1'b1;
                        phase_in               = PH_DONE;
                     end else if (max_chars == 8'd0) begin
                        phase_in = PH_DONE;
                     end else begin
                        remain_in = (data_byte < max_chars) ? data_byte : max_chars;
                        phase_in  = PH_SSID;
                     end
                  end else begin
                     remain_in = data_byte;
                     phase_in  = (data_byte == 8'd0) ? PH_TAG : PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  remain_in = remain_dec;
                  if (remain_dec == 8'd0) begin
                     phase_in = PH_TAG;
                  end
               end
               PH_SSID: begin
                  remain_in              = remain_dec;
                  result.valid           = 1'b1;
                  result.item.ssid_char  = printable;
                  result.item.ssid_last  = (remain_dec == 8'd0);
                  result.item.ssid_empty = 1'b0;
                  if (remain_dec == 8'd0) begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end

      // nothing moves without an accepted item
      if (!item_accept) begin
         pos_in    = pos_ff;
         phase_in  = phase_ff;
         long_in   = long_ff;
         tag_in    = tag_ff;
         remain_in = remain_ff;
         result    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 12'd0;
         phase_ff  <= PH_DONE;
         long_ff   <= 1'b0;
         tag_ff    <= 8'd0;
         remain_ff <= 8'd0;
      end else begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         long_ff   <= long_in;
         tag_ff    <= tag_in;
         remain_ff <= remain_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/wse_out_queue.sv */
`default_nettype none

module wse_out_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire wse_pkg::rsp_item_type push_item,
   output logic                       full,
   output logic                       head_valid,
   output wse_pkg::rsp_item_type      head_item,
   input  wire logic                  pop_ready
);

   wse_pkg::rsp_item_type slot0_ff, slot0_in;
   wse_pkg::rsp_item_type slot1_ff, slot1_in;
   logic [1:0]            count_ff, count_in;
   logic                  pop;

   assign head_valid = (count_ff != 2'd0);
   assign head_item  = slot0_ff;
   assign full       = (count_ff == 2'd2);
   assign pop        = head_valid && pop_ready;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (push && !pop) begin
         if (count_ff == 2'd0) begin
            slot0_in = push_item;
         end else begin
            slot1_in = push_item;
         end
         count_in = count_ff + 2'd1;
      end else if (push && pop) begin
         if (count_ff == 2'd1) begin
            slot0_in = push_item;
         end else begin
            slot0_in = slot1_ff;
            slot1_in = push_item;
         end
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/wifi_ssid_element_extractor_top.sv */
// a result enters the result queue as its byte is accepted, behind any earlier result
// throughput: one frame byte per cycle while the result queue is not full
// a two-item result queue keeps bytes flowing while a result waits to be taken
// reset (synchronous, active high): parser waits for a frame start, queue is empty,
// max_chars returns to 63
`default_nettype none

module wifi_ssid_element_extractor_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // data_byte[7:0], frame_len[19:8], zero[23:20]
   input  wire logic        req_tuser,   // frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // ssid_char[7:0]
   output logic             rsp_tlast,
   output logic             rsp_tuser,   // ssid_empty
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   logic                      accept;
   logic                      q_full;
   logic [7:0]                max_chars_ff;
   wse_pkg::parse_result_type result;
   wse_pkg::rsp_item_type     head_item;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= wse_pkg::MAX_CHARS_RST;
      end else if (csr_wr_en) begin
         max_chars_ff <= csr_wr_data;
      end
   end

   wse_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .item_accept (accept),
      .data_byte   (req_tdata[7:0]),
      .frame_len   (req_tdata[19:8]),
      .frame_start (req_tuser),
      .max_chars   (max_chars_ff),
      .result      (result)
   );

   wse_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (result.valid),
      .push_item  (result.item),
      .full       (q_full),
      .head_valid (rsp_tvalid),
      .head_item  (head_item),
      .pop_ready  (rsp_tready)
   );

   assign rsp_tdata = head_item.ssid_char;
   assign rsp_tlast = head_item.ssid_last;
   assign rsp_tuser = head_item.ssid_empty;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == 8'd0))
      else $error("empty result not marked last with zero char");

   a_char_printable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata >= 8'h20 && rsp_tdata < 8'h7F))
      else $error("unprintable ssid char");

   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

endmodule

`default_nettype wire

/* dv/wse_tb_pkg.sv */
`timescale 1ns / 100ps

package wse_tb_pkg;
   import wse_pkg::*;

   // frame control fields: type in bits 3:2, subtype in bits 7:4
   localparam logic [1:0] TYPE_MGMT      = 2'd0;
   localparam logic [1:0] TYPE_DATA      = 2'd2;
   localparam logic [3:0] SUB_ASSOC_REQ  = 4'd0;
   localparam logic [3:0] SUB_PROBE_REQ  = 4'd4;
   localparam logic [3:0] SUB_PROBE_RESP = 4'd5;
   localparam logic [3:0] SUB_BEACON     = 4'd8;
   localparam logic [7:0] SSID_TAG       = 8'd0;
   localparam logic [7:0] PRINT_LO       = 8'h20;
   localparam logic [7:0] PRINT_END      = 8'h7F;

   typedef enum logic [2:0] {
      PH_DONE,
      PH_HEADER,
      PH_TAG,
      PH_LEN,
      PH_SKIP,
      PH_SSID
   } parse_phase_e;

   class ssid_scoreboard;
      logic [7:0]   max_chars;
      logic [11:0]  byte_pos;
      parse_phase_e phase;
      bit           tags_long;
      logic [7:0]   elem_tag;
      logic [7:0]   elem_left;
      logic [7:0]   chars_out;
      rsp_item_type expected_chars[$];
      int           errors;
      int           frames_parsed;
      int           chars_checked;
      int           empty_ssids;
      int           truncated_runs;

      function new();
         max_chars      = MAX_CHARS_RST;
         byte_pos       = '0;
         phase          = PH_DONE;
         tags_long      = 1'b0;
         elem_tag       = '0;
         elem_left      = '0;
         chars_out      = '0;
         errors         = 0;
         frames_parsed  = 0;
         chars_checked  = 0;
         empty_ssids    = 0;
         truncated_runs = 0;
      endfunction

      function void set_max_chars(input logic [7:0] value);
         max_chars = value;
      endfunction

      // advance the parser by one accepted frame byte
      function void note_byte(input logic [7:0] data, input logic [11:0] frame_len,
                              input logic first);
         int unsigned  len;
         int unsigned  pos;
         int unsigned  tag_base;
         rsp_item_type ssid_out;
         len = (frame_len > MAX_FRAME_LEN) ? MAX_FRAME_LEN : frame_len;
         if (first) begin
            phase = PH_DONE;
            if (len >= HDR_LEN && data[3:2] == TYPE_MGMT) begin
               if ((data[7:4] == SUB_BEACON || data[7:4] == SUB_PROBE_RESP) &&
                   len >= HDR_LEN + FIXED_LEN + 2) begin
                  tags_long = 1'b1;
                  phase     = PH_HEADER;
               end else if (data[7:4] == SUB_PROBE_REQ && len >= HDR_LEN + 2) begin
                  tags_long = 1'b0;
                  phase     = PH_HEADER;
               end
            end
            if (phase == PH_HEADER) frames_parsed++;
            elem_tag  = '0;
            elem_left = '0;
            chars_out = '0;
            byte_pos  = 12'd1;
            return;
         end
         pos = byte_pos;
         if (byte_pos < MAX_FRAME_LEN) byte_pos = byte_pos + 12'd1;
         if (pos >= len || phase == PH_DONE) return;
         tag_base = tags_long ? HDR_LEN + FIXED_LEN : HDR_LEN;
         if (phase == PH_HEADER) begin
            if (pos < tag_base) return;
            phase = PH_TAG;
         end
         case (phase)
            PH_TAG: begin
               if (pos + 2 > len) phase = PH_DONE;
               else begin
                  elem_tag = data;
                  phase    = PH_LEN;
               end
            end
            PH_LEN: begin
               if (pos + 1 + data > len) phase = PH_DONE;
               else if (elem_tag == SSID_TAG) begin
                  if (data == 8'd0) begin
                     ssid_out.ssid_char  = '0;
                     ssid_out.ssid_last  = 1'b1;
                     ssid_out.ssid_empty = 1'b1;
                     expected_chars.push_back(ssid_out);
                     empty_ssids++;
                     phase = PH_DONE;
                  end else if (max_chars == 8'd0) begin
                     phase = PH_DONE;
                  end else begin
                     if (data > max_chars) truncated_runs++;
                     elem_left = (data < max_chars) ? data : max_chars;
                     chars_out = '0;
                     phase     = PH_SSID;
                  end
               end else begin
                  elem_left = data;
                  phase     = (data == 8'd0) ? PH_TAG : PH_SKIP;
               end
            end
            PH_SKIP: begin
               elem_left = elem_left - 8'd1;
               if (elem_left == 8'd0) phase = PH_TAG;
            end
            PH_SSID: begin
               elem_left = elem_left - 8'd1;
               chars_out = chars_out + 8'd1;
               ssid_out.ssid_char  = (data >= PRINT_LO && data < PRINT_END) ? data : DOT_CHAR;
               ssid_out.ssid_last  = (elem_left == 8'd0);
               ssid_out.ssid_empty = 1'b0;
               expected_chars.push_back(ssid_out);
               if (elem_left == 8'd0) phase = PH_DONE;
            end
            default: phase = PH_DONE;
         endcase
      endfunction

      function void check_result(input logic [7:0] ch, input logic last, input logic empty);
         rsp_item_type want;
         if (expected_chars.size() == 0) begin
            errors++;
            $display("%0t: ssid item with none expected: char %h last %b empty %b",
                     $time, ch, last, empty);
            return;
         end
         want = expected_chars.pop_front();
         chars_checked++;
         if (ch !== want.ssid_char) begin
            errors++;
            $display("%0t: ssid_char mismatch: expected %h actual %h", $time, want.ssid_char, ch);
         end
         if (last !== want.ssid_last) begin
            errors++;
            $display("%0t: ssid_last mismatch: expected %b actual %b", $time, want.ssid_last, last);
         end
         if (empty !== want.ssid_empty) begin
            errors++;
            $display("%0t: ssid_empty mismatch: expected %b actual %b",
                     $time, want.ssid_empty, empty);
         end
      endfunction
   endclass

endpackage

/* dv/tb_wifi_ssid_element_extractor_top.sv */
`timescale 1ns / 100ps

module tb_wifi_ssid_element_extractor_top;
   import wse_pkg::*;
   import wse_tb_pkg::*;

   localparam int CLK_HALF        = 5;
   localparam int IDLE_PCT        = 30;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int RANDOM_ITEMS    = 360;
   localparam int RANDOM_PHASES   = 4;
   localparam int DRAIN_CYCLES    = 4;
   localparam int NO_SWITCH       = 1 << 30;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   ssid_scoreboard sb;
   logic [7:0]     frame_q[$];
   bit             tx_gaps      = 1'b1;
   bit             rx_gaps      = 1'b1;
   bit             hold_off_req = 1'b0;
   int             idle_cycles  = 0;
   int             items_sent   = 0;
   int             frames_sent  = 0;
   int             settings_used = 0;

   wifi_ssid_element_extractor_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #CLK_HALF clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
         if (req_tvalid && req_tready) sb.note_byte(req_tdata[7:0], req_tdata[19:8], req_tuser);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, nothing accepted for %0d cycles", $time, idle_cycles);
         $display("tb_wifi_ssid_element_extractor_top failed");
         $finish;
      end
   end

   // result side: random back-pressure plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_tready <= !rx_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic [11:0] len, input logic first);
      while (tx_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, len, data};
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // bytes from switch_at on carry alt_len instead of len
   task automatic send_frame(input logic [11:0] len, input bit with_start = 1'b1,
                             input int switch_at = NO_SWITCH, input logic [11:0] alt_len = '0);
      foreach (frame_q[i]) send_byte(frame_q[i], (i >= switch_at) ? alt_len : len,
                                     with_start && i == 0);
      frames_sent++;
   endtask

   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_chars(input logic [7:0] value);
      pause_until_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_max_chars(value);
      settings_used++;
   endtask

   // mostly printable, with some arbitrary bytes
   function automatic logic [7:0] rand_char();
      return ($urandom_range(0, 99) < 70) ? 8'($urandom_range(32, 126)) : 8'($urandom);
   endfunction

   function automatic void start_mgmt(input logic [3:0] subtype);
      int tag_base;
      tag_base = (subtype == SUB_PROBE_REQ) ? HDR_LEN : HDR_LEN + FIXED_LEN;
      frame_q.delete();
      frame_q.push_back({subtype, TYPE_MGMT, 2'($urandom)});
      repeat (tag_base - 1) frame_q.push_back(8'($urandom));
   endfunction

   function automatic void add_element(input logic [7:0] tag, input int body_len);
      frame_q.push_back(tag);
      frame_q.push_back(8'(body_len));
      repeat (body_len) frame_q.push_back(rand_char());
   endfunction

   task automatic send_random_frame();
      int          sel;
      int          ssid_len;
      int          size;
      int          switch_at;
      logic [3:0]  subtype;
      logic [11:0] len;
      logic [11:0] alt_len;
      sel       = $urandom_range(0, 99);
      switch_at = NO_SWITCH;
      alt_len   = '0;
      if (sel >= 85) begin
         // loose bytes with no start; they may continue a frame left open
         frame_q.delete();
         repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom));
         send_frame(12'($urandom), 1'b0);
         return;
      end
      case ($urandom_range(0, 2))
         0:       subtype = SUB_BEACON;
         1:       subtype = SUB_PROBE_RESP;
         default: subtype = SUB_PROBE_REQ;
      endcase
      start_mgmt(subtype);
      repeat ($urandom_range(0, 3)) add_element(8'($urandom_range(1, 255)), $urandom_range(0, 10));
      case ($urandom_range(0, 19))
         0, 1:      ssid_len = 0;
         2, 3, 4:   ssid_len = $urandom_range(13, 40);
         5:         ssid_len = $urandom_range(41, 255);
         default:   ssid_len = $urandom_range(1, 12);
      endcase
      add_element(SSID_TAG, ssid_len);
      // later elements, possibly a second ssid that must be ignored
      repeat ($urandom_range(0, 2)) add_element(8'($urandom), $urandom_range(0, 6));
      size = frame_q.size();
      len  = 12'(size);
      if (sel < 65) begin
         case ($urandom_range(0, 9))
            0, 1: len = 12'(size + $urandom_range(1, 3));
            2:    len = 12'(size - $urandom_range(1, ssid_len + 2));
            3:    len = 12'($urandom_range(size, 4095));
            4: begin
               switch_at = $urandom_range(1, size - 1);
               alt_len   = 12'($urandom_range(0, size + 4));
            end
            default: ;
         endcase
      end else begin
         // broken header: any frame control byte, often a short length
         frame_q[0] = 8'($urandom);
         if ($urandom_range(0, 1)) len = 12'($urandom_range(0, 40));
      end
      repeat ($urandom_range(0, 2)) frame_q.push_back(8'($urandom));
      send_frame(len, 1'b1, switch_at, alt_len);
   endtask

   initial begin
      int target;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bytes while no frame is open
      frame_q = '{8'h00, 8'h80, 8'hFF};
      send_frame(12'd4095, 1'b0);
      // shortest probe request and beacon, each with an empty ssid
      start_mgmt(SUB_PROBE_REQ);
      add_element(SSID_TAG, 0);
      send_frame(12'd26);
      start_mgmt(SUB_BEACON);
      add_element(SSID_TAG, 0);
      send_frame(12'd38);
      // printable range borders after a skipped element
      start_mgmt(SUB_PROBE_RESP);
      add_element(8'd221, 3);
      frame_q = {frame_q, SSID_TAG, 8'd8, 8'h1F, 8'h20, 8'h41, 8'h7E, 8'h7F, 8'h80, 8'hFF, 8'h00};
      send_frame(12'(frame_q.size()));
      // ssid body runs past the frame end
      start_mgmt(SUB_BEACON);
      add_element(SSID_TAG, 10);
      send_frame(12'(frame_q.size() - 1));
      // data frame, wrong management subtype, beacon one byte short, shorter than a header
      start_mgmt(SUB_BEACON);
      add_element(SSID_TAG, 3);
      frame_q[0] = {SUB_BEACON, TYPE_DATA, 2'd0};
      send_frame(12'(frame_q.size()));
      frame_q[0] = {SUB_ASSOC_REQ, TYPE_MGMT, 2'd0};
      send_frame(12'(frame_q.size()));
      start_mgmt(SUB_BEACON);
      add_element(SSID_TAG, 0);
      send_frame(12'd37);
      start_mgmt(SUB_PROBE_REQ);
      add_element(SSID_TAG, 0);
      send_frame(12'd23);
      // one byte left where a tag would start, then bytes past the end
      start_mgmt(SUB_PROBE_REQ);
      add_element(8'd5, 0);
      frame_q = {frame_q, SSID_TAG, SSID_TAG, 8'd0};
      send_frame(12'd27);
      // frame length drops below the ssid body halfway through it
      start_mgmt(SUB_PROBE_REQ);
      add_element(SSID_TAG, 4);
      send_frame(12'd30, 1'b1, 26, 12'd28);
      // no characters, a single one, a cut run, the widest run
      write_max_chars(8'd0);
      start_mgmt(SUB_PROBE_REQ);
      add_element(SSID_TAG, 5);
      send_frame(12'(frame_q.size()));
      write_max_chars(8'd1);
      start_mgmt(SUB_PROBE_REQ);
      add_element(SSID_TAG, 3);
      send_frame(12'(frame_q.size()));
      write_max_chars(8'd3);
      start_mgmt(SUB_PROBE_RESP);
      add_element(SSID_TAG, 10);
      send_frame(12'(frame_q.size()));
      write_max_chars(8'd255);
      start_mgmt(SUB_BEACON);
      add_element(SSID_TAG, 255);
      send_frame(12'(frame_q.size()));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       write_max_chars(MAX_CHARS_RST);
            1:       write_max_chars(8'd255);
            2:       write_max_chars(8'($urandom_range(1, 255)));
            default: write_max_chars(8'($urandom_range(1, 8)));
         endcase
         tx_gaps = (p != 1);
         rx_gaps = (p != 1);
         if (p == 1) begin
            // result side stalls while a long ssid keeps coming
            hold_off_req = 1'b1;
            start_mgmt(SUB_BEACON);
            add_element(SSID_TAG, 40);
            send_frame(12'(frame_q.size()));
         end
         target = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
         while (items_sent < target) send_random_frame();
      end

      pause_until_drained();
      $display("covered %0d frames (%0d parsed) in %0d items under %0d max_chars settings",
               frames_sent, sb.frames_parsed, items_sent, settings_used);
      $display("checked %0d ssid items, %0d empty ssids, %0d cut runs, %0d errors",
               sb.chars_checked, sb.empty_ssids, sb.truncated_runs, sb.errors);
      if (sb.errors == 0) $display("tb_wifi_ssid_element_extractor_top passed");
      else $display("tb_wifi_ssid_element_extractor_top failed");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/wse_pkg.sv
hw/rtl/wse_parser.sv
hw/rtl/wse_out_queue.sv
hw/rtl/wifi_ssid_element_extractor_top.sv
dv/wse_tb_pkg.sv
dv/tb_wifi_ssid_element_extractor_top.sv
